// File: design/event_loop_recorder_top_assert.svh
// Assertion macros used by the event loop recorder sequencer.
`ifndef EVENT_LOOP_RECORDER_TOP_ASSERT_SVH
`define EVENT_LOOP_RECORDER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ELR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ELR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/elr_pkg.sv
// Package with types and constants of the event loop recorder.
`timescale 1ns / 1ps

package elr_pkg;

    localparam int EVENT_DEPTH = 32;
    localparam int CELL_COUNT  = 5;
    localparam int CELL_W      = 3;
    localparam int EV_AW       = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
    localparam int CNT_W       = 6;
    localparam logic [15:0] MIN_LOOP_RESET = 16'd100;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_REC  = 2'd1,
        MODE_PLAY = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        FUNC_RECORD = 2'd0,
        FUNC_TOGGLE = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REL,
        ST_DIVW,
        ST_PLAY_RD,
        ST_PLAY_CK,
        ST_STATUS
    } seq_state_t;

    typedef enum logic {
        REG_MIN_LOOP = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  cell_req;
        logic        pressed;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic        is_cell_event;
        logic [2:0]  out_cell;
        logic        out_pressed;
        logic [31:0] stamp_ms;
        logic [1:0]  mode;
        logic [5:0]  stored_events;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [31:0]       offset;
        logic [CELL_W-1:0] cell_id;
        logic              pressed;
    } ev_t;

    typedef struct packed {
        logic             we;
        logic [EV_AW-1:0] addr;
        ev_t              data;
    } store_wr_t;

    typedef struct packed {
        logic             re;
        logic [EV_AW-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } rem_req_t;

endpackage

// File: design/event_loop_recorder_top.sv
// Event loop recorder top level: APB register, store, remainder unit, sequencer.
//
// Requests enter on s_valid/s_ready with s_data (func, cell_req, pressed,
// now_ms). Each request yields zero or more played or released cell events
// followed by one status result with last set, on m_valid/m_ready with m_data.
// The block works on one request at a time. A record, or a toggle outside
// playback, goes straight to its status result; a clear, or a toggle in
// playback, first releases each held cell as a cell event. A tick in
// playback reads the store and then checks one stored event per cycle while
// the output register is free, emitting each due event; the scan stops at
// the first event not yet due or at the end of the store, and then the
// status result is loaded. A tick that wraps the loop starts the 32-step
// remainder unit that finds the new loop base, and releases held cells
// while that unit runs. The next request is taken in the cycle after the
// status result is loaded. The min_loop_ms register sits at APB address 0
// and resets to 100. After the synchronous reset the block is idle with an
// empty store. When the receiver stalls, one result waits in the output
// register and the sequencer holds until it is taken; no result is lost.
`timescale 1ns / 1ps

module event_loop_recorder_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    input  logic           s_valid,
    output logic           s_ready,
    input  elr_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output elr_pkg::out_t  m_data
);
    import elr_pkg::*;

    logic [15:0] min_loop_reg, min_loop_next;
    reg_idx_t    reg_sel;
    store_wr_t   st_wr;
    store_rd_t   st_rd;
    ev_t         st_rdata;
    rem_req_t    div_req;
    logic        div_busy;
    logic [31:0] div_rem;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb begin
        min_loop_next = min_loop_reg;
        prdata        = '0;
        unique case (reg_sel)
            REG_MIN_LOOP: begin
                prdata = {16'b0, min_loop_reg};
                if (psel && penable && pwrite) begin
                    min_loop_next = pwdata[15:0];
                end
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_loop_reg <= MIN_LOOP_RESET;
        end else begin
            min_loop_reg <= min_loop_next;
        end
    end

    elr_store u_store (
        .aclk  (aclk),
        .wr    (st_wr),
        .rd    (st_rd),
        .rdata (st_rdata)
    );

    elr_rem u_rem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .busy    (div_busy),
        .rem     (div_rem)
    );

    elr_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .min_loop_ms (min_loop_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .st_wr       (st_wr),
        .st_rd       (st_rd),
        .st_rdata    (st_rdata),
        .div_req     (div_req),
        .div_busy    (div_busy),
        .div_rem     (div_rem)
    );

endmodule

// File: design/elr_store.sv
// Event store: synchronous memory with one write and one registered read port.
`timescale 1ns / 1ps

module elr_store (
    input  logic                aclk,
    input  elr_pkg::store_wr_t  wr,
    input  elr_pkg::store_rd_t  rd,
    output elr_pkg::ev_t        rdata
);
    import elr_pkg::*;

    ev_t mem [EVENT_DEPTH];
    ev_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.re) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/elr_rem.sv
// Iterative remainder unit: one quotient bit per cycle.
`timescale 1ns / 1ps

module elr_rem (
    input  logic              aclk,
    input  logic              aresetn,
    input  elr_pkg::rem_req_t req,
    output logic              busy,
    output logic [31:0]       rem
);
    import elr_pkg::*;

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] div_reg, div_next;
    logic [32:0] trial;
    logic        fits;

    always_comb begin
        trial = {rem_reg, quo_reg[31]};
        fits  = trial >= {1'b0, div_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? 32'(trial - {1'b0, div_reg}) : trial[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

// File: design/elr_seq.sv
// Sequencer: mode state, store access, playback, release and result register.
`timescale 1ns / 1ps
`include "event_loop_recorder_top_assert.svh"

module elr_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        min_loop_ms,
    input  logic               s_valid,
    output logic               s_ready,
    input  elr_pkg::in_t       s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output elr_pkg::out_t      m_data,
    output elr_pkg::store_wr_t st_wr,
    output elr_pkg::store_rd_t st_rd,
    input  elr_pkg::ev_t       st_rdata,
    output elr_pkg::rem_req_t  div_req,
    input  logic               div_busy,
    input  logic [31:0]        div_rem
);
    import elr_pkg::*;

    seq_state_t            state_reg, state_next;
    mode_t                 mode_reg, mode_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [31:0]           rec_start_reg, rec_start_next;
    logic [31:0]           loop_len_reg, loop_len_next;
    logic [31:0]           loop_base_reg, loop_base_next;
    logic [CNT_W-1:0]      ptr_reg, ptr_next;
    logic [CELL_COUNT-1:0] held_reg, held_next;
    logic [31:0]           phase_reg, phase_next;
    logic [31:0]           stamp_reg, stamp_next;
    logic                  clr_reg, clr_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  out_free;
    logic                  load;
    out_t                  load_data;
    logic [CELL_W-1:0]     rel_idx;
    logic [CNT_W-1:0]      ptr_inc;
    logic [31:0]           rec_len;
    logic [31:0]           tick_len;
    logic [31:0]           tick_phase;
    logic                  clear_op;

    assign out_free = !m_valid_reg || m_ready;
    assign ptr_inc  = ptr_reg + 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        rel_idx = '0;
        for (int i = CELL_COUNT - 1; i >= 0; i--) begin
            if (held_reg[i]) begin
                rel_idx = CELL_W'(i);
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        total_next     = total_reg;
        rec_start_next = rec_start_reg;
        loop_len_next  = loop_len_reg;
        loop_base_next = loop_base_reg;
        ptr_next       = ptr_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        stamp_next     = stamp_reg;
        clr_next       = clr_reg;
        load           = 1'b0;
        load_data      = '0;
        st_wr          = '0;
        st_rd          = '0;
        div_req        = '0;

        rec_len = s_data.now_ms - rec_start_reg;
        if (rec_len < {16'b0, min_loop_ms}) begin
            rec_len = {16'b0, min_loop_ms};
        end
        if (rec_len == 32'd0) begin
            rec_len = 32'd1;
        end
        tick_len   = (loop_len_reg == 32'd0) ? 32'd1 : loop_len_reg;
        tick_phase = s_data.now_ms - loop_base_reg;
        clear_op   = (func_t'(s_data.func) == FUNC_CLEAR)
                  || ((func_t'(s_data.func) == FUNC_TOGGLE)
                      && (mode_reg != MODE_IDLE) && (mode_reg != MODE_REC));

        load_data.stamp_ms      = stamp_reg;
        load_data.mode          = mode_reg;
        load_data.stored_events = total_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    stamp_next = s_data.now_ms;
                    clr_next   = 1'b0;
                    state_next = ST_STATUS;
                    if (clear_op) begin
                        total_next = '0;
                        mode_next  = MODE_IDLE;
                        ptr_next   = '0;
                        clr_next   = 1'b1;
                        state_next = ST_REL;
                    end else begin
                        unique case (func_t'(s_data.func))
                            FUNC_RECORD: begin
                                if ((mode_reg == MODE_REC)
                                    && ({1'b0, s_data.cell_req} < 4'(CELL_COUNT))
                                    && (total_reg < CNT_W'(EVENT_DEPTH))) begin
                                    st_wr.we   = 1'b1;
                                    st_wr.addr = total_reg[EV_AW-1:0];
                                    st_wr.data.offset  = s_data.now_ms - rec_start_reg;
                                    st_wr.data.cell_id = s_data.cell_req;
                                    st_wr.data.pressed = s_data.pressed;
                                    total_next = total_reg + 1'b1;
                                end
                            end
                            FUNC_TOGGLE: begin
                                if (mode_reg == MODE_IDLE) begin
                                    total_next     = '0;
                                    rec_start_next = s_data.now_ms;
                                    mode_next      = MODE_REC;
                                end else if (total_reg == '0) begin
                                    mode_next = MODE_IDLE;
                                end else begin
                                    loop_len_next  = rec_len;
                                    loop_base_next = s_data.now_ms;
                                    ptr_next       = '0;
                                    held_next      = '0;
                                    mode_next      = MODE_PLAY;
                                end
                            end
                            FUNC_TICK: begin
                                if ((mode_reg == MODE_PLAY) && (total_reg != '0)) begin
                                    if (tick_phase >= tick_len) begin
                                        div_req.start    = 1'b1;
                                        div_req.dividend = tick_phase;
                                        div_req.divisor  = tick_len;
                                        state_next       = ST_REL;
                                    end else begin
                                        phase_next = tick_phase;
                                        state_next = ST_PLAY_RD;
                                    end
                                end
                            end
                            default: begin
                                state_next = ST_STATUS;
                            end
                        endcase
                    end
                end
            end
            ST_REL: begin
                if (held_reg != '0) begin
                    if (out_free) begin
                        load                    = 1'b1;
                        load_data.is_cell_event = 1'b1;
                        load_data.out_cell      = rel_idx;
                        held_next[rel_idx]      = 1'b0;
                    end
                end else if (clr_reg) begin
                    state_next = ST_STATUS;
                end else begin
                    state_next = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (!div_busy) begin
                    loop_base_next = stamp_reg - div_rem;
                    phase_next     = div_rem;
                    ptr_next       = '0;
                    state_next     = ST_PLAY_RD;
                end
            end
            ST_PLAY_RD: begin
                if (ptr_reg < total_reg) begin
                    st_rd.re   = 1'b1;
                    st_rd.addr = ptr_reg[EV_AW-1:0];
                    state_next = ST_PLAY_CK;
                end else begin
                    state_next = ST_STATUS;
                end
            end
            ST_PLAY_CK: begin
                if (st_rdata.offset > phase_reg) begin
                    state_next = ST_STATUS;
                end else if (out_free) begin
                    if ({1'b0, st_rdata.cell_id} < 4'(CELL_COUNT)) begin
                        load                    = 1'b1;
                        load_data.is_cell_event = 1'b1;
                        load_data.out_cell      = st_rdata.cell_id;
                        load_data.out_pressed   = st_rdata.pressed;
                        held_next[st_rdata.cell_id] = st_rdata.pressed;
                    end
                    ptr_next = ptr_inc;
                    if (ptr_inc < total_reg) begin
                        st_rd.re   = 1'b1;
                        st_rd.addr = ptr_inc[EV_AW-1:0];
                    end else begin
                        state_next = ST_STATUS;
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    load           = 1'b1;
                    load_data.last = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (load) begin
            m_valid_next = 1'b1;
            m_data_next  = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            total_reg     <= '0;
            rec_start_reg <= '0;
            loop_len_reg  <= '0;
            loop_base_reg <= '0;
            ptr_reg       <= '0;
            held_reg      <= '0;
            clr_reg       <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            total_reg     <= total_next;
            rec_start_reg <= rec_start_next;
            loop_len_reg  <= loop_len_next;
            loop_base_reg <= loop_base_next;
            ptr_reg       <= ptr_next;
            held_reg      <= held_next;
            clr_reg       <= clr_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg  <= phase_next;
        stamp_reg  <= stamp_next;
        m_data_reg <= m_data_next;
    end

    `ELR_ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != ST_IDLE,
        "accepted request did not start processing")
    `ELR_ASSERT_SAME(a_ptr_in_range, mode_reg == MODE_PLAY, ptr_reg <= total_reg,
        "play pointer beyond stored events")
    `ELR_ASSERT_SAME(a_held_only_in_play, (mode_reg != MODE_PLAY) && (state_reg == ST_IDLE),
        held_reg == '0, "cells held outside playback")
    `ELR_ASSERT_SAME(a_event_not_last, m_valid && m_data.is_cell_event, !m_data.last,
        "cell event marked as last result")

endmodule

// File: tb/sv/tb_event_loop_recorder_top.sv
// Self-checking testbench for the event loop recorder top level.
`timescale 1ns / 1ps

module tb_event_loop_recorder_top;
    import elr_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_REQUESTS = 60;
    localparam int QUIET_FROM = 40;
    localparam logic [2:0] MIN_LOOP_ADDR = 3'd4 * REG_MIN_LOOP;
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;

    // Mirror of the recorder state.
    logic [31:0]           ev_offset [EVENT_DEPTH];
    logic [2:0]            ev_cell [EVENT_DEPTH];
    logic                  ev_press [EVENT_DEPTH];
    int                    ev_count = 0;
    mode_t                 cur_mode = MODE_IDLE;
    logic [31:0]           rec_start = '0;
    logic [31:0]           loop_len = '0;
    logic [31:0]           loop_base = '0;
    int                    play_ptr = 0;
    logic [CELL_COUNT-1:0] held_cells = '0;
    logic [15:0]           min_loop_ms = MIN_LOOP_RESET;

    out_t        step_results [$];
    out_t        pending_results [$];
    int          fail_count = 0;
    int          live_requests = 0;
    int          idle_cycles = 0;
    bit          src_gaps_on = 1'b1;
    bit          sink_stalls_on = 1'b1;
    int          sink_hold_cycles = 0;
    int          sink_stall_left = 0;
    logic [31:0] now_clock = '0;

    event_loop_recorder_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void emit_cell(input int cell_num, input logic prs,
                                      input logic [31:0] now);
        out_t r;
        r = '0;
        r.is_cell_event = 1'b1;
        r.out_cell = 3'(cell_num);
        r.out_pressed = prs;
        r.stamp_ms = now;
        step_results.push_back(r);
    endfunction

    function automatic void release_held(input logic [31:0] now);
        for (int c = 0; c < CELL_COUNT; c++) begin
            if (held_cells[c]) begin
                emit_cell(c, 1'b0, now);
                held_cells[c] = 1'b0;
            end
        end
    endfunction

    function automatic void clear_recorder(input logic [31:0] now);
        release_held(now);
        ev_count = 0;
        cur_mode = MODE_IDLE;
        play_ptr = 0;
    endfunction

    task automatic predict_request(input in_t req);
        logic [31:0] span;
        logic [31:0] phase;
        out_t st;
        step_results.delete();
        case (func_t'(req.func))
            FUNC_RECORD: begin
                if (cur_mode == MODE_REC && req.cell_req < CELL_COUNT
                        && ev_count < EVENT_DEPTH) begin
                    ev_offset[ev_count] = req.now_ms - rec_start;
                    ev_cell[ev_count] = req.cell_req;
                    ev_press[ev_count] = req.pressed;
                    ev_count++;
                end
            end
            FUNC_TOGGLE: begin
                case (cur_mode)
                    MODE_IDLE: begin
                        ev_count = 0;
                        rec_start = req.now_ms;
                        cur_mode = MODE_REC;
                    end
                    MODE_REC: begin
                        span = req.now_ms - rec_start;
                        if (span < {16'd0, min_loop_ms}) span = {16'd0, min_loop_ms};
                        if (span == 32'd0) span = 32'd1;
                        if (ev_count == 0) begin
                            cur_mode = MODE_IDLE;
                        end else begin
                            loop_len = span;
                            loop_base = req.now_ms;
                            play_ptr = 0;
                            held_cells = '0;
                            cur_mode = MODE_PLAY;
                        end
                    end
                    default: clear_recorder(req.now_ms);
                endcase
            end
            FUNC_TICK: begin
                if (cur_mode == MODE_PLAY && ev_count != 0) begin
                    span = (loop_len == 32'd0) ? 32'd1 : loop_len;
                    phase = req.now_ms - loop_base;
                    if (phase >= span) begin
                        release_held(req.now_ms);
                        loop_base = loop_base + (phase - (phase % span));
                        play_ptr = 0;
                        phase = req.now_ms - loop_base;
                    end
                    while (play_ptr < ev_count && ev_offset[play_ptr] <= phase) begin
                        emit_cell(ev_cell[play_ptr], ev_press[play_ptr], req.now_ms);
                        held_cells[ev_cell[play_ptr]] = ev_press[play_ptr];
                        play_ptr++;
                    end
                end
            end
            default: clear_recorder(req.now_ms);
        endcase
        st = '0;
        st.stamp_ms = req.now_ms;
        st.last = 1'b1;
        step_results.push_back(st);
        foreach (step_results[i]) begin
            step_results[i].mode = cur_mode;
            step_results[i].stored_events = 6'(ev_count);
            pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_request(input func_t f, input logic [2:0] cell_num, input logic prs,
                                input logic [31:0] now);
        in_t req;
        int gap;
        req.func = f;
        req.cell_req = cell_num;
        req.pressed = prs;
        req.now_ms = now;
        if (src_gaps_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            repeat (gap) @(negedge aclk);
        end
        s_data = req;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(req);
        live_requests++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (addr == MIN_LOOP_ADDR) min_loop_ms = data[15:0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic report_failure(input string what, input out_t exp_r, input out_t act_r);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected ev=%0d cell=%0d prs=%0d stamp=%h mode=%0d stored=%0d last=%0d",
                     exp_r.is_cell_event, exp_r.out_cell, exp_r.out_pressed, exp_r.stamp_ms,
                     exp_r.mode, exp_r.stored_events, exp_r.last);
            $display("  actual   ev=%0d cell=%0d prs=%0d stamp=%h mode=%0d stored=%0d last=%0d",
                     act_r.is_cell_event, act_r.out_cell, act_r.out_pressed, act_r.stamp_ms,
                     act_r.mode, act_r.stored_events, act_r.last);
        end
    endtask

    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_failure("result with no request pending", '0, m_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.is_cell_event !== exp_r.is_cell_event
                        || m_data.out_cell !== exp_r.out_cell
                        || m_data.out_pressed !== exp_r.out_pressed
                        || m_data.stamp_ms !== exp_r.stamp_ms
                        || m_data.mode !== exp_r.mode
                        || m_data.stored_events !== exp_r.stored_events
                        || m_data.last !== exp_r.last)
                    report_failure("result mismatch", exp_r, m_data);
            end
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready = 1'b0;
                sink_hold_cycles--;
            end else if (sink_stall_left > 0) begin
                m_ready = 1'b0;
                sink_stall_left--;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                sink_stall_left = $urandom_range(0, 16);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("event_loop_recorder_top test failed");
                $finish;
            end
        end
    end

    task automatic test_idle_behavior();
        send_request(FUNC_TICK, 3'd0, 1'b0, 32'h0000_0000);
        send_request(FUNC_RECORD, 3'd3, 1'b1, 32'h0000_0001);
        send_request(FUNC_CLEAR, 3'd7, 1'b1, 32'h0000_0002);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, 32'h0000_000A);
        send_request(FUNC_RECORD, 3'd5, 1'b1, 32'h0000_000C);
        send_request(FUNC_RECORD, 3'd6, 1'b0, 32'h0000_000D);
        send_request(FUNC_RECORD, 3'd7, 1'b1, 32'h0000_000E);
        send_request(FUNC_TICK, 3'd0, 1'b0, 32'h0000_000F);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, 32'h0000_0014);
    endtask

    task automatic test_directed_loop();
        logic [31:0] t0;
        logic [31:0] lb;
        t0 = 32'hFFFF_FFF0;
        lb = t0 + 32'd30;
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, t0);
        send_request(FUNC_RECORD, 3'd0, 1'b1, t0 + 32'd5);
        send_request(FUNC_RECORD, 3'd4, 1'b1, t0 + 32'd10);
        send_request(FUNC_RECORD, 3'd2, 1'b1, t0 + 32'd12);
        send_request(FUNC_RECORD, 3'd0, 1'b0, t0 + 32'd20);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, lb);
        send_request(FUNC_TICK, 3'd0, 1'b0, lb);
        send_request(FUNC_TICK, 3'd0, 1'b0, lb + 32'd10);
        send_request(FUNC_TICK, 3'd0, 1'b0, lb + 32'd25);
        send_request(FUNC_TICK, 3'd0, 1'b0, lb + 32'd99);
        send_request(FUNC_TICK, 3'd0, 1'b0, lb + 32'd350);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, lb + 32'd360);
    endtask

    task automatic test_store_limits();
        logic [31:0] t0;
        wait_for_drain();
        write_register(MIN_LOOP_ADDR, 32'hFFFF_0000);
        t0 = $urandom;
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, t0);
        repeat (EVENT_DEPTH + 2)
            send_request(FUNC_RECORD, 3'($urandom_range(0, CELL_COUNT - 1)),
                         1'($urandom_range(0, 1)), t0);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, t0);
        send_request(FUNC_TICK, 3'd0, 1'b0, t0);
        send_request(FUNC_TICK, 3'd0, 1'b0, t0 + 32'd1);
        send_request(FUNC_CLEAR, 3'd0, 1'b0, t0 + 32'd1);
    endtask

    task automatic test_long_loop();
        logic [31:0] t0;
        wait_for_drain();
        write_register(MIN_LOOP_ADDR, 32'h0000_FFFF);
        write_register(SPARE_ADDR, 32'h0000_0007);
        t0 = $urandom;
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, t0);
        send_request(FUNC_RECORD, 3'd1, 1'b1, t0 + 32'd1);
        send_request(FUNC_RECORD, 3'd3, 1'b1, t0 + 32'd2);
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, t0 + 32'd3);
        send_request(FUNC_TICK, 3'd0, 1'b0, t0 + 32'd3 + 32'd65534);
        send_request(FUNC_TICK, 3'd0, 1'b0, t0 + 32'd3 + 32'd65535);
        send_request(FUNC_TICK, 3'd0, 1'b0, t0 + 32'd3 + 32'd200001);
        send_request(FUNC_CLEAR, 3'd0, 1'b0, t0 + 32'd200010);
        wait_for_drain();
        write_register(MIN_LOOP_ADDR, 32'h0000_0001);
    endtask

    task automatic test_backpressure();
        wait_for_drain();
        write_register(MIN_LOOP_ADDR, 32'd20);
        now_clock = $urandom;
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, now_clock);
        repeat (6) begin
            now_clock += $urandom_range(0, 3);
            send_request(FUNC_RECORD, 3'($urandom_range(0, CELL_COUNT - 1)),
                         1'($urandom_range(0, 1)), now_clock);
        end
        send_request(FUNC_TOGGLE, 3'd0, 1'b0, now_clock);
        sink_hold_cycles = 400;
        repeat (12) begin
            now_clock += 32'd7;
            send_request(FUNC_TICK, 3'd0, 1'b0, now_clock);
        end
        wait_for_drain();
        send_request(FUNC_CLEAR, 3'd0, 1'b0, now_clock);
    endtask

    task automatic test_random_sessions();
        int start_count;
        int n_rec;
        int n_tick;
        int pick;
        start_count = live_requests;
        while (live_requests - start_count < RANDOM_REQUESTS) begin
            if (live_requests - start_count >= QUIET_FROM) begin
                src_gaps_on = 1'b0;
                sink_stalls_on = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                wait_for_drain();
                pick = $urandom_range(0, 9);
                if (pick == 0) write_register(MIN_LOOP_ADDR, 32'h0000_FFFF);
                else if (pick == 1) write_register(MIN_LOOP_ADDR, $urandom);
                else write_register(MIN_LOOP_ADDR, $urandom_range(1, 60));
            end
            if ($urandom_range(0, 9) == 0) now_clock = $urandom;
            else now_clock += $urandom_range(0, 1000);
            send_request(FUNC_TOGGLE, 3'($urandom), 1'($urandom), now_clock);
            n_rec = ($urandom_range(0, 11) == 0) ? EVENT_DEPTH + 2 : $urandom_range(0, 12);
            repeat (n_rec) begin
                now_clock += $urandom_range(0, 15);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_request(func_t'($urandom_range(0, 3)), 3'($urandom), 1'($urandom),
                                 $urandom);
                else if (pick == 1)
                    send_request(FUNC_RECORD, 3'($urandom), 1'($urandom), now_clock);
                else
                    send_request(FUNC_RECORD, 3'($urandom_range(0, CELL_COUNT - 1)),
                                 1'($urandom), now_clock);
            end
            now_clock += $urandom_range(0, 20);
            send_request(FUNC_TOGGLE, 3'($urandom), 1'($urandom), now_clock);
            n_tick = $urandom_range(2, 14);
            repeat (n_tick) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) now_clock += $urandom_range(0, 20);
                else if (pick < 9) now_clock += $urandom_range(0, 400);
                else now_clock = $urandom;
                send_request(FUNC_TICK, 3'($urandom), 1'($urandom), now_clock);
            end
            pick = $urandom_range(0, 4);
            if (pick < 2)
                send_request(FUNC_CLEAR, 3'($urandom), 1'($urandom), now_clock);
            else if (pick < 4)
                send_request(FUNC_TOGGLE, 3'($urandom), 1'($urandom), now_clock);
        end
        send_request(FUNC_CLEAR, 3'd0, 1'b0, now_clock);
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_idle_behavior();
        test_directed_loop();
        test_store_limits();
        test_long_loop();
        test_backpressure();
        test_random_sessions();
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("event_loop_recorder_top test passed");
        end else begin
            $display("event_loop_recorder_top test failed");
        end
        $finish;
    end

endmodule

// File: event_loop_recorder_top.f
+incdir+design
design/elr_pkg.sv
design/elr_store.sv
design/elr_rem.sv
design/elr_seq.sv
design/event_loop_recorder_top.sv
tb/sv/tb_event_loop_recorder_top.sv
